>>> design/sbge_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stereo biquad equalizer core.
// No dependencies; imported by every module of the block.
package sbge_pkg;

    localparam int BANDS          = 10;
    localparam int COEF_FRAC_BITS = 28;
    localparam int NUM_COEF       = 5;
    localparam int BAND_IDX_W     = 4;
    localparam int SEL_W          = 3;
    localparam int SAMPLE_W       = 32;
    localparam int PROD_W         = 64;
    localparam int ACC_W          = 67;
    localparam int STEP_W         = 3;
    localparam int VPROD_W        = 49;
    localparam int PADDR_W        = 3;

    localparam logic [PADDR_W-1:0] ADDR_EQ_ENABLE   = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_VOLUME_GAIN = 3'd4;

    localparam logic [15:0] VOLUME_RESET = 16'h8000;

    // coefficient select codes
    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_COEF  = 1'b1;

    // cell sequence: five product steps, an accumulate drain, then round/saturate
    localparam logic [STEP_W-1:0] STEP_LAST_MUL = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ROUND    = 3'd6;

    typedef struct packed {
        logic                           wr;
        logic [BAND_IDX_W-1:0]          band;
        logic [SEL_W-1:0]               sel;
        logic signed [SAMPLE_W-1:0]     value;
    } coef_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_VOL,
        ST_SCALE
    } state_t;

endpackage

>>> design/sbge_cell.sv
`timescale 1ns / 1ps
// One biquad band for both channels: coefficients, history and a multiplier per channel.
// Depends on sbge_pkg.
module sbge_cell
    import sbge_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [BAND_IDX_W-1:0]       cell_idx,
    input  coef_wr_t                    coef_wr,
    input  logic                        start,
    input  logic signed [SAMPLE_W-1:0]  x_l,
    input  logic signed [SAMPLE_W-1:0]  x_r,
    output logic                        done,
    output logic signed [SAMPLE_W-1:0]  y_l,
    output logic signed [SAMPLE_W-1:0]  y_r
);

    localparam logic signed [SAMPLE_W-1:0] COEF_ONE = SAMPLE_W'(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0]    RND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]    SAT_MAX  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0]    SAT_MIN  = -ACC_W'(64'sd2147483648);

    logic signed [SAMPLE_W-1:0] coef_reg [NUM_COEF];
    logic signed [SAMPLE_W-1:0] x1_l_reg, x2_l_reg, y1_l_reg, y2_l_reg;
    logic signed [SAMPLE_W-1:0] x1_r_reg, x2_r_reg, y1_r_reg, y2_r_reg;
    logic signed [SAMPLE_W-1:0] xin_l_reg, xin_r_reg;
    logic signed [PROD_W-1:0]   prod_l_reg, prod_r_reg;
    logic signed [ACC_W-1:0]    acc_l_reg, acc_r_reg;
    logic                       busy_reg, pvalid_reg, pneg_reg, done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] yout_l_reg, yout_r_reg;

    logic signed [SAMPLE_W-1:0] c_sel, op_l, op_r;
    logic signed [ACC_W-1:0]    addend_l, addend_r;
    logic signed [ACC_W-1:0]    rnd_l, rnd_r;
    logic signed [SAMPLE_W-1:0] sat_l, sat_r;

    always_comb
    begin
        case (step_reg)
            SEL_B0:
            begin
                c_sel = coef_reg[0]; op_l = xin_l_reg; op_r = xin_r_reg;
            end
            SEL_B1:
            begin
                c_sel = coef_reg[1]; op_l = x1_l_reg; op_r = x1_r_reg;
            end
            SEL_B2:
            begin
                c_sel = coef_reg[2]; op_l = x2_l_reg; op_r = x2_r_reg;
            end
            SEL_A1:
            begin
                c_sel = coef_reg[3]; op_l = y1_l_reg; op_r = y1_r_reg;
            end
            SEL_A2:
            begin
                c_sel = coef_reg[4]; op_l = y2_l_reg; op_r = y2_r_reg;
            end
            default:
            begin
                c_sel = '0; op_l = '0; op_r = '0;
            end
        endcase
    end

    always_comb
    begin
        addend_l = ACC_W'(prod_l_reg);
        addend_r = ACC_W'(prod_r_reg);
        if (pneg_reg)
        begin
            addend_l = -addend_l;
            addend_r = -addend_r;
        end
        // round to nearest, ties up, then drop fraction bits
        rnd_l = (acc_l_reg + RND_HALF) >>> COEF_FRAC_BITS;
        rnd_r = (acc_r_reg + RND_HALF) >>> COEF_FRAC_BITS;
        if (rnd_l > SAT_MAX)
            sat_l = SAT_MAX[SAMPLE_W-1:0];
        else if (rnd_l < SAT_MIN)
            sat_l = SAT_MIN[SAMPLE_W-1:0];
        else
            sat_l = rnd_l[SAMPLE_W-1:0];
        if (rnd_r > SAT_MAX)
            sat_r = SAT_MAX[SAMPLE_W-1:0];
        else if (rnd_r < SAT_MIN)
            sat_r = SAT_MIN[SAMPLE_W-1:0];
        else
            sat_r = rnd_r[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= (i == 0) ? COEF_ONE : '0;
            x1_l_reg <= '0; x2_l_reg <= '0; y1_l_reg <= '0; y2_l_reg <= '0;
            x1_r_reg <= '0; x2_r_reg <= '0; y1_r_reg <= '0; y2_r_reg <= '0;
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            pneg_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (coef_wr.wr)
            begin
                if (coef_wr.band == cell_idx)
                    coef_reg[coef_wr.sel] <= coef_wr.value;
                x1_l_reg <= '0; x2_l_reg <= '0; y1_l_reg <= '0; y2_l_reg <= '0;
                x1_r_reg <= '0; x2_r_reg <= '0; y1_r_reg <= '0; y2_r_reg <= '0;
            end
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                pvalid_reg <= (step_reg <= STEP_LAST_MUL);
                pneg_reg   <= (step_reg >= SEL_A1);
                if (step_reg == STEP_ROUND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    x2_l_reg <= x1_l_reg; x1_l_reg <= xin_l_reg;
                    y2_l_reg <= y1_l_reg; y1_l_reg <= sat_l;
                    x2_r_reg <= x1_r_reg; x1_r_reg <= xin_r_reg;
                    y2_r_reg <= y1_r_reg; y1_r_reg <= sat_r;
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xin_l_reg <= x_l;
            xin_r_reg <= x_r;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_l_reg <= c_sel * op_l;
            prod_r_reg <= c_sel * op_r;
            if (pvalid_reg)
            begin
                acc_l_reg <= acc_l_reg + addend_l;
                acc_r_reg <= acc_r_reg + addend_r;
            end
            if (step_reg == STEP_ROUND)
            begin
                yout_l_reg <= sat_l;
                yout_r_reg <= sat_r;
            end
        end
    end

    assign done = done_reg;
    assign y_l  = yout_l_reg;
    assign y_r  = yout_r_reg;

endmodule

>>> design/stereo_biquad_graphic_equalizer_core.sv
`timescale 1ns / 1ps
// Top level: APB registers, sequencer, chain of band cells, volume and PCM output stage.
// Depends on sbge_pkg and sbge_cell.
//
//  channel | signals                         | direction
//  in      | in_valid / in_stall + fields    | word into block
//  out     | out_valid / out_stall + fields  | word out of block
//  cfg     | APB psel/penable/pwrite/paddr   | register access
//
// Each band in the cell chain steps through one load, 5 multiply steps, one
// accumulate drain and one round; a bypassed frame skips the chain. A
// coefficient write leaves the input free for the next word. The output
// register lets a new word in while a result waits; the last stage holds
// when the output is stalled. Reset sets b0 to one and clears history; no clearing pass.
module stereo_biquad_graphic_equalizer_core
    import sbge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic signed [15:0]  left_in,
    input  logic signed [15:0]  right_in,
    input  logic                frame_last,
    input  logic [3:0]          band_index,
    input  logic [2:0]          coef_select,
    input  logic signed [31:0]  coef_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  left_out,
    output logic signed [15:0]  right_out,
    output logic                last_out
);

    localparam logic signed [VPROD_W-1:0] ONE_Q838 = VPROD_W'(64'sd1 <<< 38);

    logic        eq_enable_reg;
    logic [15:0] volume_gain_reg;

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] samp_l_reg, samp_r_reg;
    logic signed [VPROD_W-1:0]  vprod_l_reg, vprod_r_reg;
    logic                       last_reg;
    logic                       out_valid_reg;
    logic signed [15:0]         left_out_reg, right_out_reg;
    logic                       last_out_reg;

    logic in_acc, frame_acc, coef_ok, chain_start, load_out, out_free;
    coef_wr_t coef_wr;

    logic                       cell_start [BANDS];
    logic                       cell_done  [BANDS];
    logic signed [SAMPLE_W-1:0] cell_xl    [BANDS];
    logic signed [SAMPLE_W-1:0] cell_xr    [BANDS];
    logic signed [SAMPLE_W-1:0] cell_yl    [BANDS];
    logic signed [SAMPLE_W-1:0] cell_yr    [BANDS];

    logic signed [SAMPLE_W-1:0] in_l_q, in_r_q;
    logic signed [15:0]         pcm_l, pcm_r;

    // PCM conversion: clamp to +-1.0, scale by 32767, round half away from zero
    function automatic logic signed [15:0] to_pcm(input logic signed [VPROD_W-1:0] v);
        logic signed [VPROD_W-1:0] c;
        logic                      neg;
        logic [38:0]               m;
        logic [53:0]               s;
        logic [15:0]               q;
        c = v;
        if (v > ONE_Q838)
            c = ONE_Q838;
        if (v < -ONE_Q838)
            c = -ONE_Q838;
        neg = c[VPROD_W-1];
        m   = neg ? 39'(-c) : 39'(c);
        s   = ({15'd0, m} << 15) - {15'd0, m} + (54'd1 << 37);
        q   = s[53:38];
        return neg ? -$signed(q) : $signed(q);
    endfunction

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_enable_reg   <= 1'b0;
            volume_gain_reg <= VOLUME_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_EQ_ENABLE)
                eq_enable_reg <= pwdata[0];
            else if (paddr == ADDR_VOLUME_GAIN)
                volume_gain_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr == ADDR_EQ_ENABLE)
            prdata = {31'd0, eq_enable_reg};
        else if (paddr == ADDR_VOLUME_GAIN)
            prdata = {16'd0, volume_gain_reg};
        else
            prdata = '0;
    end

    assign in_acc    = in_valid && !in_stall;
    assign frame_acc = in_acc && (req_type == REQ_FRAME);
    assign coef_ok   = (band_index < BAND_IDX_W'(BANDS)) && (coef_select <= SEL_A2);
    assign out_free  = !out_valid_reg || !out_stall;

    assign coef_wr.wr    = in_acc && (req_type == REQ_COEF) && coef_ok;
    assign coef_wr.band  = band_index;
    assign coef_wr.sel   = coef_select;
    assign coef_wr.value = coef_value;

    assign in_l_q = {{8{left_in[15]}}, left_in, 8'd0};
    assign in_r_q = {{8{right_in[15]}}, right_in, 8'd0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (frame_acc)
                    state_next = eq_enable_reg ? ST_RUN : ST_VOL;
            ST_RUN:
                if (cell_done[BANDS-1])
                    state_next = ST_VOL;
            ST_VOL:
                state_next = ST_SCALE;
            ST_SCALE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall    = 1'b1;
        chain_start = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                chain_start = frame_acc && eq_enable_reg;
            end
            ST_RUN:   ;
            ST_VOL:   ;
            ST_SCALE:
                load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            samp_l_reg <= in_l_q;
            samp_r_reg <= in_r_q;
            last_reg   <= frame_last;
        end
        else if (state_reg == ST_RUN && cell_done[BANDS-1])
        begin
            samp_l_reg <= cell_yl[BANDS-1];
            samp_r_reg <= cell_yr[BANDS-1];
        end
        if (state_reg == ST_VOL)
        begin
            vprod_l_reg <= samp_l_reg * $signed({1'b0, volume_gain_reg});
            vprod_r_reg <= samp_r_reg * $signed({1'b0, volume_gain_reg});
        end
        if (load_out)
        begin
            left_out_reg  <= pcm_l;
            right_out_reg <= pcm_r;
            last_out_reg  <= last_reg;
        end
    end

    assign pcm_l = to_pcm(vprod_l_reg);
    assign pcm_r = to_pcm(vprod_r_reg);

    genvar b;
    generate
        for (b = 0; b < BANDS; b++)
        begin : g_band
            if (b == 0)
            begin : g_head
                assign cell_start[b] = chain_start;
                assign cell_xl[b]    = in_l_q;
                assign cell_xr[b]    = in_r_q;
            end
            else
            begin : g_link
                assign cell_start[b] = cell_done[b-1];
                assign cell_xl[b]    = cell_yl[b-1];
                assign cell_xr[b]    = cell_yr[b-1];
            end

            sbge_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (BAND_IDX_W'(b)),
                .coef_wr  (coef_wr),
                .start    (cell_start[b]),
                .x_l      (cell_xl[b]),
                .x_r      (cell_xr[b]),
                .done     (cell_done[b]),
                .y_l      (cell_yl[b]),
                .y_r      (cell_yr[b])
            );
        end
    endgenerate

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign last_out  = last_out_reg;

endmodule

>>> design/sbge_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the equalizer core, attached by bind.
// Depends on sbge_pkg.
module sbge_checker
    import sbge_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               req_type,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] left_out,
    input logic signed [15:0] right_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("stalled output word changed");

    a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_out != 16'sh8000 && right_out != 16'sh8000)
        else $error("output sample outside clamp range");

    a_coef_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_COEF |=> !in_stall)
        else $error("coefficient write held input");

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_FRAME |=> in_stall)
        else $error("frame accepted without going busy");

endmodule

bind stereo_biquad_graphic_equalizer_core sbge_checker u_sbge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
);
